// ----- src/mpmi_pkg.sv -----
package mpmi_pkg;

    // Access side.
    localparam logic SIDE_MCU  = 1'b0;
    localparam logic SIDE_MAIN = 1'b1;

    // Access direction.
    localparam logic OP_READ  = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // Microcontroller register map.
    localparam logic [2:0] MCU_ADDR_PORT_A = 3'd0;
    localparam logic [2:0] MCU_ADDR_PORT_B = 3'd1;
    localparam logic [2:0] MCU_ADDR_PORT_C = 3'd2;
    localparam logic [2:0] MCU_ADDR_DIR_A  = 3'd4;
    localparam logic [2:0] MCU_ADDR_DIR_B  = 3'd5;
    localparam logic [2:0] MCU_ADDR_DIR_C  = 3'd6;

    // Main CPU register map.
    localparam logic [2:0] MAIN_ADDR_DATA   = 3'd0;
    localparam logic [2:0] MAIN_ADDR_STATUS = 3'd1;

    // Handshake bit positions on port B, on port C and in the status byte.
    localparam int BIT_LOW  = 0;
    localparam int BIT_TAKE = 1;
    localparam int BIT_GIVE = 2;

    typedef struct packed {
        logic       side;
        logic       opcode;
        logic [2:0] address;
        logic [7:0] write_data;
    } req_t;

    typedef struct packed {
        logic [7:0] read_data;
        logic       mcu_irq;
    } rsp_t;

endpackage

// ----- src/mpmi_if.sv -----
interface mpmi_req_if;
    logic             valid;
    logic             ready;
    mpmi_pkg::req_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface mpmi_rsp_if;
    logic             valid;
    logic             ready;
    mpmi_pkg::rsp_t   payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

// ----- src/mpmi_in_stage.sv -----
module mpmi_in_stage (
    input  logic            clk,
    input  logic            rst_n,
    mpmi_req_if.sink        req,
    input  logic            advance,
    output logic            item_valid,
    output mpmi_pkg::req_t  item
);

    logic           valid_reg;
    logic           valid_next;
    mpmi_pkg::req_t item_reg;
    logic           load;

    // The register can take a word when empty or when its word moves on.
    assign req.ready = !valid_reg || advance;
    assign load      = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (advance)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            item_reg <= req.payload;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ----- src/mpmi_core.sv -----
module mpmi_core (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            fire,
    input  mpmi_pkg::req_t  item,
    output mpmi_pkg::rsp_t  result
);

    logic [7:0] port_a_latch_out_reg, port_a_latch_out_next;
    logic [7:0] port_a_pins_in_reg,   port_a_pins_in_next;
    logic [7:0] dir_a_reg,            dir_a_next;
    logic [7:0] port_b_latch_out_reg, port_b_latch_out_next;
    logic [7:0] dir_b_reg,            dir_b_next;
    logic [7:0] port_c_latch_out_reg, port_c_latch_out_next;
    logic [7:0] dir_c_reg,            dir_c_next;
    logic [7:0] host_to_mcu_byte_reg, host_to_mcu_byte_next;
    logic [7:0] mcu_to_host_byte_reg, mcu_to_host_byte_next;
    logic       host_pending_reg,     host_pending_next;
    logic       reply_pending_reg,    reply_pending_next;
    logic       irq_level_reg,        irq_level_next;

    logic [7:0] port_c_pins;
    logic [7:0] status_byte;
    logic [7:0] read_data;
    logic       take_edge;
    logic       give_edge;

    always_comb
    begin
        port_c_pins = 8'h00;
        port_c_pins[mpmi_pkg::BIT_LOW]  = host_pending_reg;
        port_c_pins[mpmi_pkg::BIT_TAKE] = !reply_pending_reg;

        status_byte = 8'h00;
        status_byte[mpmi_pkg::BIT_LOW]  = !host_pending_reg;
        status_byte[mpmi_pkg::BIT_TAKE] = reply_pending_reg;
    end

    // Port B handshake edges compare the old latch against the incoming byte.
    assign take_edge = dir_b_reg[mpmi_pkg::BIT_TAKE]
                    && !item.write_data[mpmi_pkg::BIT_TAKE]
                    && port_b_latch_out_reg[mpmi_pkg::BIT_TAKE];
    assign give_edge = dir_b_reg[mpmi_pkg::BIT_GIVE]
                    && item.write_data[mpmi_pkg::BIT_GIVE]
                    && !port_b_latch_out_reg[mpmi_pkg::BIT_GIVE];

    always_comb
    begin
        port_a_latch_out_next = port_a_latch_out_reg;
        port_a_pins_in_next   = port_a_pins_in_reg;
        dir_a_next            = dir_a_reg;
        port_b_latch_out_next = port_b_latch_out_reg;
        dir_b_next            = dir_b_reg;
        port_c_latch_out_next = port_c_latch_out_reg;
        dir_c_next            = dir_c_reg;
        host_to_mcu_byte_next = host_to_mcu_byte_reg;
        mcu_to_host_byte_next = mcu_to_host_byte_reg;
        host_pending_next     = host_pending_reg;
        reply_pending_next    = reply_pending_reg;
        irq_level_next        = irq_level_reg;
        read_data             = 8'h00;

        if (item.side == mpmi_pkg::SIDE_MCU)
        begin
            if (item.opcode == mpmi_pkg::OP_WRITE)
            begin
                unique case (item.address)
                    mpmi_pkg::MCU_ADDR_PORT_A: port_a_latch_out_next = item.write_data;
                    mpmi_pkg::MCU_ADDR_PORT_B:
                    begin
                        if (take_edge)
                        begin
                            port_a_pins_in_next = host_to_mcu_byte_reg;
                            host_pending_next   = 1'b0;
                            if (host_pending_reg)
                            begin
                                irq_level_next = 1'b0;
                            end
                        end
                        if (give_edge)
                        begin
                            mcu_to_host_byte_next = port_a_latch_out_reg;
                            reply_pending_next    = 1'b1;
                        end
                        port_b_latch_out_next = item.write_data;
                    end
                    mpmi_pkg::MCU_ADDR_PORT_C: port_c_latch_out_next = item.write_data;
                    mpmi_pkg::MCU_ADDR_DIR_A:  dir_a_next = item.write_data;
                    mpmi_pkg::MCU_ADDR_DIR_B:  dir_b_next = item.write_data;
                    mpmi_pkg::MCU_ADDR_DIR_C:  dir_c_next = item.write_data;
                    default: ;
                endcase
            end
            else
            begin
                unique case (item.address)
                    mpmi_pkg::MCU_ADDR_PORT_A:
                        read_data = (port_a_latch_out_reg & dir_a_reg)
                                  | (port_a_pins_in_reg & ~dir_a_reg);
                    // Port B input pins read as zero.
                    mpmi_pkg::MCU_ADDR_PORT_B:
                        read_data = port_b_latch_out_reg & dir_b_reg;
                    mpmi_pkg::MCU_ADDR_PORT_C:
                        read_data = (port_c_latch_out_reg & dir_c_reg)
                                  | (port_c_pins & ~dir_c_reg);
                    default: read_data = 8'h00;
                endcase
            end
        end
        else
        begin
            if (item.opcode == mpmi_pkg::OP_WRITE)
            begin
                if (item.address == mpmi_pkg::MAIN_ADDR_DATA)
                begin
                    host_to_mcu_byte_next = item.write_data;
                    host_pending_next     = 1'b1;
                    irq_level_next        = 1'b1;
                end
            end
            else
            begin
                unique case (item.address)
                    mpmi_pkg::MAIN_ADDR_DATA:
                    begin
                        reply_pending_next = 1'b0;
                        read_data          = mcu_to_host_byte_reg;
                    end
                    mpmi_pkg::MAIN_ADDR_STATUS: read_data = status_byte;
                    default: read_data = 8'h00;
                endcase
            end
        end

        result.read_data = read_data;
        result.mcu_irq   = irq_level_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            port_a_latch_out_reg <= 8'h00;
            port_a_pins_in_reg   <= 8'h00;
            dir_a_reg            <= 8'h00;
            port_b_latch_out_reg <= 8'h00;
            dir_b_reg            <= 8'h00;
            port_c_latch_out_reg <= 8'h00;
            dir_c_reg            <= 8'h00;
            host_to_mcu_byte_reg <= 8'h00;
            mcu_to_host_byte_reg <= 8'h00;
            host_pending_reg     <= 1'b0;
            reply_pending_reg    <= 1'b0;
            irq_level_reg        <= 1'b0;
        end
        else if (fire)
        begin
            port_a_latch_out_reg <= port_a_latch_out_next;
            port_a_pins_in_reg   <= port_a_pins_in_next;
            dir_a_reg            <= dir_a_next;
            port_b_latch_out_reg <= port_b_latch_out_next;
            dir_b_reg            <= dir_b_next;
            port_c_latch_out_reg <= port_c_latch_out_next;
            dir_c_reg            <= dir_c_next;
            host_to_mcu_byte_reg <= host_to_mcu_byte_next;
            mcu_to_host_byte_reg <= mcu_to_host_byte_next;
            host_pending_reg     <= host_pending_next;
            reply_pending_reg    <= reply_pending_next;
            irq_level_reg        <= irq_level_next;
        end
    end

    // The interrupt line follows the pending flag exactly.
    assert property (@(posedge clk) disable iff (!rst_n)
        irq_level_reg == host_pending_reg)
        else $error("interrupt level and pending flag disagree");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.side == mpmi_pkg::SIDE_MAIN && item.opcode == mpmi_pkg::OP_WRITE
        && item.address == mpmi_pkg::MAIN_ADDR_DATA
        |=> host_pending_reg && irq_level_reg)
        else $error("main data write did not raise the interrupt");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.side == mpmi_pkg::SIDE_MAIN && item.opcode == mpmi_pkg::OP_READ
        && item.address == mpmi_pkg::MAIN_ADDR_DATA
        |=> !reply_pending_reg)
        else $error("main data read left the reply flag set");

    assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.opcode == mpmi_pkg::OP_WRITE |-> result.read_data == 8'h00)
        else $error("write access returned nonzero data");

endmodule

// ----- src/mpmi_out_stage.sv -----
module mpmi_out_stage (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  mpmi_pkg::rsp_t  result,
    output logic            busy,
    mpmi_rsp_if.source      rsp
);

    logic           valid_reg;
    logic           valid_next;
    mpmi_pkg::rsp_t result_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result;
        end
    end

    // The register holds a word that the sink has not yet taken.
    assign busy        = valid_reg && !rsp.ready;
    assign rsp.valid   = valid_reg;
    assign rsp.payload = result_reg;

endmodule

// ----- src/mcu_port_mailbox_interface.sv -----
// Access words wait in the input register; result words in the result register.
// Throughput: one access word per cycle, sustained while the result side keeps taking.
// The rate is set by the single pass through the port and mailbox logic between the
// input register and the result register.
// Reset (rst_n, asynchronous, active low) clears all ports, direction registers,
// mailbox bytes and flags, and empties both registers.
module mcu_port_mailbox_interface (
    input  logic        clk,
    input  logic        rst_n,
    mpmi_req_if.sink    req,
    mpmi_rsp_if.source  rsp
);

    logic           item_valid;
    mpmi_pkg::req_t item;
    mpmi_pkg::rsp_t result;
    logic           out_busy;
    logic           advance;

    // A held access word moves into the core, and updates the mailbox state,
    // only in the cycle in which its result can be registered. Accesses are
    // therefore applied to the state strictly in acceptance order.
    assign advance = item_valid && !out_busy;

    mpmi_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // Port latches, direction registers, the two mailbox bytes and the
    // handshake flags live in the core, which computes the read byte and the
    // new interrupt level for one access in a single combinational pass.
    mpmi_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (advance),
        .item   (item),
        .result (result)
    );

    // The result register decouples the two sides, so a new access can be
    // accepted while a finished result still waits to be taken.
    mpmi_out_stage u_out_stage (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (advance),
        .result (result),
        .busy   (out_busy),
        .rsp    (rsp)
    );

endmodule
